[src/gif_lzw_decoder_defines.svh]
// assertion macros for the gif lzw decoder
`ifndef GIF_LZW_DECODER_DEFINES_SVH
`define GIF_LZW_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define GLZ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define GLZ_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define GLZ_ASSERT(lbl, prop, msg)
`define GLZ_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

[src/gif_lzw_pkg.sv]
package gif_lzw_pkg;

    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int STACK_AW = 12;
    localparam logic [3:0] MIN_CODE_RESET = 4'd8;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       start_image;
    } t_req;

    typedef struct packed {
        logic       accepted;
        logic       pixel_valid;
        logic [7:0] pixel_index;
        logic       image_done;
        logic       code_error;
    } t_res;

endpackage

[src/gif_lzw_front.sv]
module gif_lzw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gif_lzw_pkg::t_req  i_req,
    output logic               o_full,
    output logic               o_req_valid,
    output gif_lzw_pkg::t_req  o_req,
    input  logic               i_req_pop
);
    import gif_lzw_pkg::*;

    t_req       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full      = (r_cnt == 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_mem[r_rd];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_req_pop && o_req_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

[src/gif_lzw_back.sv]
module gif_lzw_back #(
    parameter int MAX_CODE_BITS = gif_lzw_pkg::MAX_CODE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [3:0]         i_min_code_size,
    input  logic               i_req_valid,
    input  gif_lzw_pkg::t_req  i_req,
    output logic               o_req_pop,
    input  logic               i_res_free,
    output logic               o_res_write,
    output gif_lzw_pkg::t_res  o_res
);
    import gif_lzw_pkg::*;

    localparam int CW     = MAX_CODE_BITS;
    localparam int NF_W   = CW + 1;
    localparam int BUF_W  = CW + 8;
    localparam int DEPTH  = 1 << CW;
    localparam int SDEPTH = 1 << STACK_AW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_WREAD = 3'd4;

    logic [CW-1:0]     m_prefix [DEPTH];
    logic [7:0]        m_suffix [DEPTH];
    logic [7:0]        m_stack  [SDEPTH];

    logic [2:0]        r_state, n_state;
    logic [STACK_AW:0] r_sc, n_sc;
    logic [BUF_W-1:0]  r_buf, n_buf;
    logic [4:0]        r_bc, n_bc;
    logic [3:0]        r_cw, n_cw;
    logic [NF_W-1:0]   r_nf, n_nf;
    logic [CW-1:0]     r_prev, n_prev;
    logic [7:0]        r_first, n_first;
    logic              r_ac, n_ac;
    logic              r_end, n_end;
    logic              r_err, n_err;
    logic [CW-1:0]     r_cur, n_cur;
    logic [CW-1:0]     r_code, n_code;
    logic [STACK_AW:0] r_guard, n_guard;
    logic              r_acc, n_acc;
    logic              r_valid, n_valid;
    logic [7:0]        r_pix, n_pix;

    logic [7:0]        r_stk_rd;
    logic [CW-1:0]     r_pre_rd;
    logic [7:0]        r_suf_rd;

    logic                stk_we;
    logic [STACK_AW-1:0] stk_ra;
    logic                dict_we;
    logic [CW-1:0]       dict_ra;
    logic                push_en;
    logic [7:0]          push_val;

    logic [3:0]        w_eff;
    logic [CW-1:0]     w_clear;
    logic [CW-1:0]     w_code;
    logic [NF_W-1:0]   w_nf_inc;

    assign w_eff    = (i_min_code_size < 4'd2) ? 4'd2 :
                      (i_min_code_size > 4'd8) ? 4'd8 : i_min_code_size;
    assign w_clear  = CW'(1) << w_eff;
    assign w_code   = CW'(r_buf & ((BUF_W'(1) << r_cw) - BUF_W'(1)));
    assign w_nf_inc = r_nf + NF_W'(1);
    assign stk_ra   = STACK_AW'(r_sc - (STACK_AW + 1)'(1));
    assign dict_ra  = r_cur;

    assign o_res.accepted    = r_acc;
    assign o_res.pixel_valid = r_valid;
    assign o_res.pixel_index = r_pix;
    assign o_res.image_done  = r_end && (r_sc == '0);
    assign o_res.code_error  = r_err;

    always_comb begin
        n_state     = r_state;
        n_sc        = r_sc;
        n_buf       = r_buf;
        n_bc        = r_bc;
        n_cw        = r_cw;
        n_nf        = r_nf;
        n_prev      = r_prev;
        n_first     = r_first;
        n_ac        = r_ac;
        n_end       = r_end;
        n_err       = r_err;
        n_cur       = r_cur;
        n_code      = r_code;
        n_guard     = r_guard;
        n_acc       = r_acc;
        n_valid     = r_valid;
        n_pix       = r_pix;
        o_req_pop   = 1'b0;
        o_res_write = 1'b0;
        dict_we     = 1'b0;
        push_en     = 1'b0;
        push_val    = 8'd0;
        stk_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    n_valid   = 1'b0;
                    n_pix     = 8'd0;
                    n_acc     = 1'b0;
                    n_state   = S_DRAIN;
                    if (i_req.req_type) begin
                        if (r_sc != '0) begin
                            n_sc    = r_sc - (STACK_AW + 1)'(1);
                            n_valid = 1'b1;
                            n_state = S_POP;
                        end
                    end else if (i_req.start_image) begin
                        n_sc    = '0;
                        n_buf   = BUF_W'(i_req.data_byte);
                        n_bc    = 5'd8;
                        n_prev  = '0;
                        n_first = 8'd0;
                        n_end   = 1'b0;
                        n_err   = 1'b0;
                        n_cw    = w_eff + 4'd1;
                        n_nf    = NF_W'(w_clear) + NF_W'(2);
                        n_ac    = 1'b1;
                        n_acc   = 1'b1;
                    end else if (r_end || r_err) begin
                        n_acc = 1'b1;
                    end else if (r_sc == '0 && r_bc < {1'b0, r_cw}) begin
                        n_acc = 1'b1;
                        n_buf = r_buf | (BUF_W'(i_req.data_byte) << r_bc);
                        n_bc  = r_bc + 5'd8;
                    end
                end
            end
            S_POP: begin
                n_pix   = r_stk_rd;
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (r_sc == '0 && !r_end && !r_err && r_bc >= {1'b0, r_cw}) begin
                    n_buf = r_buf >> r_cw;
                    n_bc  = r_bc - {1'b0, r_cw};
                    if (w_code == w_clear) begin
                        n_cw = w_eff + 4'd1;
                        n_nf = NF_W'(w_clear) + NF_W'(2);
                        n_ac = 1'b1;
                    end else if (w_code == w_clear + CW'(1)) begin
                        n_end = 1'b1;
                    end else if ({1'b0, w_code} > r_nf || (r_ac && w_code >= w_clear)) begin
                        n_err = 1'b1;
                    end else if (r_ac) begin
                        push_en  = 1'b1;
                        push_val = w_code[7:0];
                        n_first  = w_code[7:0];
                        n_prev   = w_code;
                        n_ac     = 1'b0;
                    end else begin
                        n_code  = w_code;
                        n_guard = '0;
                        n_state = S_WALK;
                        if ({1'b0, w_code} == r_nf) begin
                            push_en  = 1'b1;
                            push_val = r_first;
                            n_cur    = r_prev;
                        end else begin
                            n_cur = w_code;
                        end
                    end
                end else if (i_res_free) begin
                    o_res_write = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_WALK: begin
                if (r_cur >= w_clear && !r_guard[STACK_AW]) begin
                    n_state = S_WREAD;
                end else begin
                    push_en  = 1'b1;
                    push_val = r_cur[7:0];
                    n_first  = r_cur[7:0];
                    if (!r_nf[CW]) begin
                        dict_we = 1'b1;
                        n_nf    = w_nf_inc;
                        if (w_nf_inc == (NF_W'(1) << r_cw) && r_cw < 4'(CW)) begin
                            n_cw = r_cw + 4'd1;
                        end
                    end
                    n_prev  = r_code;
                    n_state = S_DRAIN;
                end
            end
            S_WREAD: begin
                push_en  = 1'b1;
                push_val = r_suf_rd;
                n_cur    = r_pre_rd;
                n_guard  = r_guard + (STACK_AW + 1)'(1);
                n_state  = S_WALK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (push_en && !r_sc[STACK_AW]) begin
            stk_we = 1'b1;
            n_sc   = r_sc + (STACK_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            m_stack[r_sc[STACK_AW-1:0]] <= push_val;
        end
        r_stk_rd <= m_stack[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dict_we) begin
            m_prefix[r_nf[CW-1:0]] <= r_prev;
            m_suffix[r_nf[CW-1:0]] <= r_cur[7:0];
        end
        r_pre_rd <= m_prefix[dict_ra];
        r_suf_rd <= m_suffix[dict_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sc    <= '0;
            r_buf   <= '0;
            r_bc    <= 5'd0;
            r_cw    <= MIN_CODE_RESET + 4'd1;
            r_nf    <= (NF_W'(1) << MIN_CODE_RESET) + NF_W'(2);
            r_prev  <= '0;
            r_first <= 8'd0;
            r_ac    <= 1'b1;
            r_end   <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sc    <= n_sc;
            r_buf   <= n_buf;
            r_bc    <= n_bc;
            r_cw    <= n_cw;
            r_nf    <= n_nf;
            r_prev  <= n_prev;
            r_first <= n_first;
            r_ac    <= n_ac;
            r_end   <= n_end;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_code  <= n_code;
        r_guard <= n_guard;
        r_acc   <= n_acc;
        r_valid <= n_valid;
        r_pix   <= n_pix;
    end

endmodule

[src/gif_lzw_decoder.sv]
// a push or empty pull goes idle to drain, which writes the result; a pixel pull passes pop
// each code after the first goes to walk, with a dictionary read state per table chain entry
// the back end takes a new request only when idle, after it has written the last result
// a waiting result stalls the back end only at the result write of the following request
// reset: synchronous active low, clears queues and decoder state, min code size 8
// dictionary and pixel stack are not cleared by reset
`include "gif_lzw_decoder_defines.svh"

module gif_lzw_decoder #(
    parameter int MAX_CODE_BITS = gif_lzw_pkg::MAX_CODE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_image,
    output logic        empty,
    input  logic        pop,
    output logic        o_accepted,
    output logic        o_pixel_valid,
    output logic [7:0]  o_pixel_index,
    output logic        o_image_done,
    output logic        o_code_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gif_lzw_pkg::*;

    localparam logic [2:0] ADDR_MIN_CODE = 3'd0;

    t_req       w_in_req;
    t_req       w_req;
    logic       w_req_valid;
    logic       w_req_pop;
    logic       w_res_write;
    t_res       w_res;
    logic [3:0] r_min;
    logic       r_res_valid;
    t_res       r_res;

    assign w_in_req.req_type    = i_req_type;
    assign w_in_req.data_byte   = i_data_byte;
    assign w_in_req.start_image = i_start_image;

    gif_lzw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_req       (w_in_req),
        .o_full      (full),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_pop   (w_req_pop)
    );

    gif_lzw_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_min_code_size (r_min),
        .i_req_valid     (w_req_valid),
        .i_req           (w_req),
        .o_req_pop       (w_req_pop),
        .i_res_free      (!r_res_valid),
        .o_res_write     (w_res_write),
        .o_res           (w_res)
    );

    // config register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MIN_CODE) ? {28'd0, r_min} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_CODE_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_MIN_CODE) begin
            r_min <= pwdata[3:0];
        end
    end

    // result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_res_write) begin
            r_res_valid <= 1'b1;
        end else if (pop && r_res_valid) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_write) begin
            r_res <= w_res;
        end
    end

    assign empty         = !r_res_valid;
    assign o_accepted    = r_res.accepted;
    assign o_pixel_valid = r_res.pixel_valid;
    assign o_pixel_index = r_res.pixel_index;
    assign o_image_done  = r_res.image_done;
    assign o_code_error  = r_res.code_error;

    `GLZ_ASSERT(a_push_or_pull, empty || !(o_accepted && o_pixel_valid), "push and pull result")
    `GLZ_ASSERT(a_done_xor_err, empty || !(o_image_done && o_code_error), "done with error")
    `GLZ_ASSERT(a_idle_pixel, empty || o_pixel_valid || o_pixel_index == 8'd0, "stray pixel")
    `GLZ_ASSERT_NEXT(a_slot_write, w_res_write, !empty, "result slot not filled")

endmodule
